// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro samples on the rising edge
// of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/uuv_pkg.sv -----
`default_nettype none

package uuv_pkg;

	// Allowed range of the next continuation byte.
	typedef enum logic [2:0] {
		RANGE_PLAIN    = 3'd0,
		RANGE_AFTER_E0 = 3'd1,
		RANGE_AFTER_ED = 3'd2,
		RANGE_AFTER_F0 = 3'd3,
		RANGE_AFTER_F4 = 3'd4
	} range_t;

	typedef enum logic [1:0] {
		VERDICT_OK       = 2'd0,
		VERDICT_NUL      = 2'd1,
		VERDICT_WIDE     = 2'd2,
		VERDICT_BAD_UTF8 = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} unit_beat_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       done_res;
		logic [1:0] verdict;
	} res_beat_t;

	// Per-string scan state. The conversion error reuses the verdict codes.
	typedef struct packed {
		logic [1:0] pending;
		range_t     rng;
		verdict_t   conv_err;
		logic       bad_utf8;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		pending:  2'd0,
		rng:      RANGE_PLAIN,
		conv_err: VERDICT_OK,
		bad_utf8: 1'b0
	};

endpackage

`default_nettype wire

// ----- sv/utf8_unit_validator_core.sv -----
// Throughput: one unit per cycle while the result side is not stalled; the
// scan state updates in the same cycle that the registered unit moves into
// the result register.
// Reset: arst_n clears both valid flags and the scan state at once, so the
// first beat after reset starts a fresh string.
`default_nettype none

`include "assert_macros.svh"

module utf8_unit_validator_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 unit_valid,
	output logic                unit_stall,
	input  wire uuv_pkg::unit_beat_t unit_beat,
	output logic                res_valid,
	input  wire                 res_stall,
	output uuv_pkg::res_beat_t  res_beat
);

	// Stage 1 holds the accepted unit. Stage 2 is the result register.
	// While the result waits to be taken, stage 1 can still hold one more
	// unit, so the upstream side keeps moving until both are full.
	logic                 valid_s1;
	uuv_pkg::unit_beat_t  beat_s1;
	logic                 res_valid_s2;
	uuv_pkg::res_beat_t   res_beat_s2;

	// Scan state for the string in flight: open sequence, sticky errors.
	uuv_pkg::scan_state_t state_q;
	uuv_pkg::scan_state_t state_next;
	uuv_pkg::res_beat_t   res_next;

	logic advance;
	logic fire;

	// The result register can load when it is empty or being drained.
	assign advance    = !res_valid_s2 || !res_stall;
	// A unit leaves stage 1 and commits its effect on the scan state.
	assign fire       = valid_s1 && advance;
	assign unit_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!unit_stall) begin
			valid_s1 <= unit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!unit_stall && unit_valid) begin
			beat_s1 <= unit_beat;
		end
	end

	uuv_step u_step (
		.state      (state_q),
		.beat       (beat_s1),
		.state_next (state_next),
		.res        (res_next)
	);

	// The scan state only moves when a unit commits; the last unit of a
	// string returns it to the start values inside the step logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uuv_pkg::SCAN_RESET;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_beat_s2 <= res_next;
		end
	end

	assign res_valid = res_valid_s2;
	assign res_beat  = res_beat_s2;

	// Upstream is only held off when stage 1 is occupied.
	`ASSERT_IMP(a_stall_needs_s1, unit_stall, valid_s1)
	// After the last unit of a string the scan state is back at its start values.
	`ASSERT_NXT(a_last_resets, fire && beat_s1.last_unit, state_q == uuv_pkg::SCAN_RESET)
	// A conversion error stays put until the string ends.
	`ASSERT_NXT(a_conv_sticky, fire && !beat_s1.last_unit && (state_q.conv_err != uuv_pkg::VERDICT_OK), state_q.conv_err == $past(state_q.conv_err))
	// A mid-string UTF-8 verdict on the result agrees with the held scan state.
	`ASSERT_IMP(a_mid_bad_matches, res_valid_s2 && !res_beat_s2.done_res && (res_beat_s2.verdict == uuv_pkg::VERDICT_BAD_UTF8), state_q.bad_utf8 && (state_q.conv_err == uuv_pkg::VERDICT_OK))

endmodule

`default_nettype wire

// ----- sv/uuv_step.sv -----
`default_nettype none

// Next-state and result logic for one code unit.
module uuv_step (
	input  wire uuv_pkg::scan_state_t state,
	input  wire uuv_pkg::unit_beat_t  beat,
	output uuv_pkg::scan_state_t      state_next,
	output uuv_pkg::res_beat_t        res
);

	logic [7:0]           b;
	logic                 tail_ok;
	logic                 cont_ok;
	uuv_pkg::scan_state_t scan;
	uuv_pkg::verdict_t    v;

	assign b       = beat.code_unit[7:0];
	assign tail_ok = (b[7:6] == 2'b10);

	always_comb begin
		unique case (state.rng)
			uuv_pkg::RANGE_AFTER_E0: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
			uuv_pkg::RANGE_AFTER_ED: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
			uuv_pkg::RANGE_AFTER_F0: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
			uuv_pkg::RANGE_AFTER_F4: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
			default:                 cont_ok = tail_ok;
		endcase
	end

	always_comb begin
		scan = state;

		// The first conversion error sticks.
		if (state.conv_err == uuv_pkg::VERDICT_OK) begin
			if (beat.code_unit == 16'd0) begin
				scan.conv_err = uuv_pkg::VERDICT_NUL;
			end else if (beat.code_unit[15:8] != 8'd0) begin
				scan.conv_err = uuv_pkg::VERDICT_WIDE;
			end
		end

		priority if (state.bad_utf8) begin
			scan.bad_utf8 = 1'b1;
		end else if (state.pending != 2'd0) begin
			if (!cont_ok) begin
				scan.bad_utf8 = 1'b1;
			end else begin
				scan.pending = state.pending - 2'd1;
				scan.rng     = uuv_pkg::RANGE_PLAIN;
			end
		end else if (!b[7]) begin
			scan.pending = state.pending;
		end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
			scan.pending = 2'd1;
			scan.rng     = uuv_pkg::RANGE_PLAIN;
		end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
			scan.pending = 2'd2;
			scan.rng     = (b == 8'hE0) ? uuv_pkg::RANGE_AFTER_E0 :
			               (b == 8'hED) ? uuv_pkg::RANGE_AFTER_ED : uuv_pkg::RANGE_PLAIN;
		end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
			scan.pending = 2'd3;
			scan.rng     = (b == 8'hF0) ? uuv_pkg::RANGE_AFTER_F0 :
			               (b == 8'hF4) ? uuv_pkg::RANGE_AFTER_F4 : uuv_pkg::RANGE_PLAIN;
		end else begin
			scan.bad_utf8 = 1'b1;
		end
	end

	always_comb begin
		priority if (scan.conv_err != uuv_pkg::VERDICT_OK) begin
			v = scan.conv_err;
		end else if (scan.bad_utf8 || (beat.last_unit && (scan.pending != 2'd0))) begin
			v = uuv_pkg::VERDICT_BAD_UTF8;
		end else begin
			v = uuv_pkg::VERDICT_OK;
		end
	end

	assign state_next   = beat.last_unit ? uuv_pkg::SCAN_RESET : scan;
	assign res.byte_out = b;
	assign res.done_res = beat.last_unit;
	assign res.verdict  = v;

endmodule

`default_nettype wire

// ----- verif/utf8_unit_validator_core_tb.sv -----
`default_nettype none

module utf8_unit_validator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uuv_pkg::*;

	// The output hold must outlast the time the block needs to fill up. The quiet
	// limit must outlast that hold plus the longest random gap on either side.
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	// One row of the directed part. When "typed" is set, the verdict column is
	// the expected verdict. Otherwise the predictor supplies it.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
		logic        typed;
		verdict_t    verdict;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:24] = '{
		// Plain ASCII right after reset, then the extremes of the unit range.
		'{16'h0041, 1'b1, 1'b1, VERDICT_OK},
		'{16'h0000, 1'b1, 1'b1, VERDICT_NUL},
		'{16'hFFFF, 1'b1, 1'b1, VERDICT_WIDE},
		// A stray continuation byte, an overlong lead and a lead above F4.
		'{16'h0080, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		'{16'h00C1, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		'{16'h00F5, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		// E0 followed by the lowest second byte that it allows.
		'{16'h00E0, 1'b0, 1'b0, VERDICT_OK},
		'{16'h00A0, 1'b0, 1'b0, VERDICT_OK},
		'{16'h0080, 1'b1, 1'b0, VERDICT_OK},
		// ED A0 would encode a surrogate.
		'{16'h00ED, 1'b0, 1'b1, VERDICT_OK},
		'{16'h00A0, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		// F4 90 would go past the last code point.
		'{16'h00F4, 1'b0, 1'b1, VERDICT_OK},
		'{16'h0090, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		// F0 8F would be an overlong four-byte form.
		'{16'h00F0, 1'b0, 1'b1, VERDICT_OK},
		'{16'h008F, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		// A two-byte lead cut off by the end of the string.
		'{16'h00DF, 1'b1, 1'b1, VERDICT_BAD_UTF8},
		// The first conversion error wins over a later NUL.
		'{16'h0100, 1'b0, 1'b1, VERDICT_WIDE},
		'{16'h0000, 1'b1, 1'b1, VERDICT_WIDE},
		// A NUL wins over a later wide unit and over a broken UTF-8 byte.
		'{16'h0001, 1'b0, 1'b1, VERDICT_OK},
		'{16'h0000, 1'b0, 1'b1, VERDICT_NUL},
		'{16'h0280, 1'b1, 1'b1, VERDICT_NUL},
		// F4 8F BF BF is the last valid code point.
		'{16'h00F4, 1'b0, 1'b0, VERDICT_OK},
		'{16'h008F, 1'b0, 1'b0, VERDICT_OK},
		'{16'h00BF, 1'b0, 1'b0, VERDICT_OK},
		'{16'h00BF, 1'b1, 1'b0, VERDICT_OK}
	};

	// Byte values on either side of every range boundary that the checker uses.
	localparam logic [7:0] BOUNDARY_BYTES [0:17] = '{
		8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hC1,
		8'hC2, 8'hDF, 8'hE0, 8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hFF
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       unit_valid = 1'b0;
	logic       unit_stall;
	unit_beat_t unit_beat = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_beat_t  res_beat;

	// Scan state of the predictor. It mirrors what the block keeps per string.
	logic [1:0] tails_left = 2'd0;
	range_t     tail_range = RANGE_PLAIN;
	verdict_t   conv_fault = VERDICT_OK;
	logic       utf8_bad = 1'b0;

	// Results that accepted units have caused and that have not come out yet,
	// oldest first.
	res_beat_t due_results [$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	logic hold_req = 1'b0;
	int  units_sent = 0;
	int  strings_sent = 0;
	int  results_seen = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;

	utf8_unit_validator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit_beat (unit_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// True when byte b is an allowed continuation byte for range code r.
	function automatic logic tail_fits(logic [7:0] b, range_t r);
		case (r)
			RANGE_AFTER_E0: return b >= 8'hA0 && b <= 8'hBF;
			RANGE_AFTER_ED: return b >= 8'h80 && b <= 8'h9F;
			RANGE_AFTER_F0: return b >= 8'h90 && b <= 8'hBF;
			RANGE_AFTER_F4: return b >= 8'h80 && b <= 8'h8F;
			default:        return b[7:6] == 2'b10;
		endcase
	endfunction

	// Advances the predicted scan state by one unit and returns the result
	// beat that the block must give for it.
	function automatic res_beat_t scan_unit(unit_beat_t u);
		logic [7:0] b;
		res_beat_t  r;
		b = u.code_unit[7:0];
		// Only the first conversion error is kept.
		if (conv_fault == VERDICT_OK) begin
			if (u.code_unit == 16'h0000)
				conv_fault = VERDICT_NUL;
			else if (u.code_unit > 16'h00FF)
				conv_fault = VERDICT_WIDE;
		end
		// The low byte goes through the UTF-8 check even for a wide unit.
		if (!utf8_bad) begin
			if (tails_left != 2'd0) begin
				if (!tail_fits(b, tail_range)) begin
					utf8_bad = 1'b1;
				end else begin
					tails_left = tails_left - 2'd1;
					tail_range = RANGE_PLAIN;
				end
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				tails_left = 2'd1;
				tail_range = RANGE_PLAIN;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				tails_left = 2'd2;
				tail_range = (b == 8'hE0) ? RANGE_AFTER_E0 :
				             (b == 8'hED) ? RANGE_AFTER_ED : RANGE_PLAIN;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				tails_left = 2'd3;
				tail_range = (b == 8'hF0) ? RANGE_AFTER_F0 :
				             (b == 8'hF4) ? RANGE_AFTER_F4 : RANGE_PLAIN;
			end else if (b >= 8'h80) begin
				utf8_bad = 1'b1;
			end
		end
		r.byte_out = b;
		r.done_res = u.last_unit;
		// A sequence still open only counts as an error on the last unit.
		if (conv_fault != VERDICT_OK)
			r.verdict = conv_fault;
		else if (utf8_bad || (u.last_unit && tails_left != 2'd0))
			r.verdict = VERDICT_BAD_UTF8;
		else
			r.verdict = VERDICT_OK;
		if (u.last_unit) begin
			tails_left = 2'd0;
			tail_range = RANGE_PLAIN;
			conv_fault = VERDICT_OK;
			utf8_bad = 1'b0;
		end
		return r;
	endfunction

	// A random continuation byte that is valid for range code r.
	function automatic logic [15:0] tail_unit(range_t r);
		case (r)
			RANGE_AFTER_E0: return 16'($urandom_range(8'hA0, 8'hBF));
			RANGE_AFTER_ED: return 16'($urandom_range(8'h80, 8'h9F));
			RANGE_AFTER_F0: return 16'($urandom_range(8'h90, 8'hBF));
			RANGE_AFTER_F4: return 16'($urandom_range(8'h80, 8'h8F));
			default:        return 16'($urandom_range(8'h80, 8'hBF));
		endcase
	endfunction

	// Appends one well-formed character of one to four bytes. The leads with a
	// narrowed second-byte range are drawn more often than the others.
	function automatic void add_char(ref logic [15:0] q [$]);
		logic [7:0] lead;
		case ($urandom_range(3))
			0: begin
				q.insert(q.size(), 16'($urandom_range(1, 8'h7F)));
			end
			1: begin
				q.insert(q.size(), 16'($urandom_range(8'hC2, 8'hDF)));
				q.insert(q.size(), tail_unit(RANGE_PLAIN));
			end
			2: begin
				case ($urandom_range(3))
					0:       lead = 8'hE0;
					1:       lead = 8'hED;
					default: lead = 8'($urandom_range(8'hE1, 8'hEF));
				endcase
				q.insert(q.size(), {8'h00, lead});
				q.insert(q.size(), tail_unit((lead == 8'hE0) ? RANGE_AFTER_E0 :
				                   (lead == 8'hED) ? RANGE_AFTER_ED : RANGE_PLAIN));
				q.insert(q.size(), tail_unit(RANGE_PLAIN));
			end
			default: begin
				case ($urandom_range(3))
					0:       lead = 8'hF0;
					1:       lead = 8'hF4;
					default: lead = 8'($urandom_range(8'hF1, 8'hF3));
				endcase
				q.insert(q.size(), {8'h00, lead});
				q.insert(q.size(), tail_unit((lead == 8'hF0) ? RANGE_AFTER_F0 :
				                   (lead == 8'hF4) ? RANGE_AFTER_F4 : RANGE_PLAIN));
				q.insert(q.size(), tail_unit(RANGE_PLAIN));
				q.insert(q.size(), tail_unit(RANGE_PLAIN));
			end
		endcase
	endfunction

	// Offers one unit beat and waits until the block takes it. The result is
	// predicted at the acceptance edge; a typed verdict from the directed
	// table replaces the predicted one.
	task automatic offer_unit(input unit_beat_t u, input logic typed, input verdict_t v);
		res_beat_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			unit_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		unit_valid <= 1'b1;
		unit_beat  <= u;
		do @(posedge clk); while (unit_stall);
		r = scan_unit(u);
		if (typed)
			r.verdict = v;
		due_results.insert(due_results.size(), r);
		units_sent++;
	endtask

	// Builds one random string and offers it. Most strings are well formed;
	// the rest are cut short, carry a bad byte, a NUL or a wide unit, or are
	// plain noise.
	task automatic offer_string();
		logic [15:0] units [$];
		int kind;
		int n;
		int pos;
		n = $urandom_range(1, 6);
		kind = $urandom_range(99);
		if (kind >= 96) begin
			repeat (n) begin
				if ($urandom_range(1) != 0)
					units.insert(units.size(), 16'($urandom_range(0, 255)));
				else
					units.insert(units.size(), 16'($urandom()));
			end
		end else begin
			repeat (n) add_char(units);
			pos = $urandom_range(units.size() - 1);
			if (kind >= 88) begin
				units[pos] = 16'($urandom_range(16'h0100, 16'hFFFF));
			end else if (kind >= 80) begin
				units.insert(pos, 16'h0000);
			end else if (kind >= 70) begin
				if ($urandom_range(1) != 0)
					units[pos] = {8'h00, BOUNDARY_BYTES[$urandom_range(17)]};
				else
					units[pos] = 16'($urandom_range(1, 255));
			end else if (kind >= 60) begin
				void'(units.pop_back());
			end
		end
		if (units.size() == 0)
			units.insert(0, 16'h0041);
		foreach (units[i])
			offer_unit(unit_beat_t'({units[i], 1'(i == units.size() - 1)}), 1'b0, VERDICT_OK);
		strings_sent++;
	endtask

	// Output side. It stalls at random at the current rate, and once in the run
	// it holds off for a long stretch so that the block backs up to its input.
	always begin
		@(posedge clk);
		if (hold_req) begin
			hold_req = 1'b0;
			res_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
		end
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Every accepted result beat is compared field by field with the oldest
	// prediction still waiting.
	always @(posedge clk) begin : check_results
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				$display("%0t: result beat %h arrived with no unit waiting for it",
				         $time, res_beat);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (res_beat.byte_out !== want.byte_out) begin
					$display("%0t: byte_out expected %h, got %h",
					         $time, want.byte_out, res_beat.byte_out);
					mismatches++;
				end
				if (res_beat.done_res !== want.done_res) begin
					$display("%0t: done_res expected %b, got %b",
					         $time, want.done_res, res_beat.done_res);
					mismatches++;
				end
				if (res_beat.verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d, got %0d",
					         $time, want.verdict, res_beat.verdict);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((unit_valid && !unit_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corner cases, with the sender idling less than the receiver.
		send_idle_pct = 32;
		recv_idle_pct = 64;
		for (int i = 0; i < $size(DIR_ROWS); i++)
			offer_unit(unit_beat_t'({DIR_ROWS[i].code_unit, DIR_ROWS[i].last_unit}),
			           DIR_ROWS[i].typed, DIR_ROWS[i].verdict);
		while (units_sent < 540)
			offer_string();

		// Now the sender is the slow side.
		send_idle_pct = 64;
		recv_idle_pct = 32;
		while (units_sent < 1050)
			offer_string();

		// Full rate on both sides, with one long hold on the output while the
		// sender keeps offering.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		while (units_sent < 1550)
			offer_string();
		unit_valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d code units in %0d strings, %0d result beats checked, %0d mismatches",
		         units_sent, strings_sent, results_seen, mismatches);
		$display("directed corner cases, three idle mixes and a long output hold");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/uuv_pkg.sv
sv/uuv_step.sv
sv/utf8_unit_validator_core.sv
verif/utf8_unit_validator_core_tb.sv
